### design/hut_pkg.sv
// Shared types, constants and helpers for the HID usage owner-count tracker.
`default_nettype none

package hut_pkg;

    localparam int BUTTONS    = 3;
    localparam int KEY_USAGES = 256;
    localparam int MODS       = 4;
    localparam int MOUSE_BTNS = 3;

    localparam int SLOT_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int KEY_W  = $clog2(KEY_USAGES);

    localparam int QDEPTH = 2;
    localparam int Q_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [1:0] COUNT_MAX     = 2'd3;
    localparam logic [1:0] TYPE_DISABLED = 2'd0;
    localparam logic [1:0] TYPE_MOUSE    = 2'd1;
    localparam logic [1:0] TYPE_KEY      = 2'd2;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_MOUSE = 2'd1;
    localparam logic [1:0] EV_MOD   = 2'd2;
    localparam logic [1:0] EV_KEY   = 2'd3;

    // last sequencer step of a keyboard item: four modifiers plus the key
    localparam logic [2:0] STEP_LAST = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE        = 2'd0,
        OP_PRESS_MOUSE = 2'd1,
        OP_PRESS_KEY   = 2'd2,
        OP_RELEASE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PL_NONE     = 3'd0,
        PL_MOUSE_DN = 3'd1,
        PL_MOUSE_UP = 3'd2,
        PL_KEY_DN   = 3'd3,
        PL_KEY_UP   = 3'd4
    } plan_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        code;
        logic [3:0]        mods;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       down;
        logic [2:0] mask;
        logic [1:0] mod_idx;
        logic [7:0] key;
        logic [2:0] held;
    } result_t;

    // host report bit of a mouse code: left 1, middle 4, right 2
    function automatic logic [2:0] host_mask(input logic [1:0] code);
        logic [2:0] m;
        unique case (code)
            2'd1:    m = 3'd1;
            2'd2:    m = 3'd4;
            2'd3:    m = 3'd2;
            default: m = 3'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### design/hut_front.sv
// Input side: accepts items and classifies them into queue commands.
`default_nettype none

module hut_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire logic          action,
    input  wire logic [1:0]    button,
    input  wire logic [1:0]    action_type,
    input  wire logic [7:0]    target_code,
    input  wire logic [3:0]    modifier_bits,
    input  wire logic          q_full,
    output logic               q_push,
    output hut_pkg::cmd_t      q_cmd
);

    logic btn_ok;
    logic mouse_ok;
    logic key_ok;
    logic seen_reg;

    assign btn_ok   = 4'(button) < 4'(hut_pkg::BUTTONS);
    assign mouse_ok = (action_type == hut_pkg::TYPE_MOUSE) &&
                      (target_code >= 8'd1) && (target_code <= 8'd3);
    assign key_ok   = (action_type == hut_pkg::TYPE_KEY) && (target_code != 8'd0) &&
                      (9'(target_code) < 9'(hut_pkg::KEY_USAGES));

    // the stall is a plain view of queue occupancy, also raised in reset;
    // seen_reg only flags that the channel has been used since reset
    assign item_stall = q_full || !rst_n;
    assign q_push     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (q_push)
        begin
            seen_reg <= 1'b1;
        end
    end

    always_comb
    begin
        q_cmd.slot = hut_pkg::SLOT_W'(button);
        q_cmd.code = target_code;
        q_cmd.mods = modifier_bits;
        if (!btn_ok)
        begin
            q_cmd.op = hut_pkg::OP_NONE;
        end
        else if (action)
        begin
            q_cmd.op = hut_pkg::OP_RELEASE;
        end
        else if (mouse_ok)
        begin
            q_cmd.op = hut_pkg::OP_PRESS_MOUSE;
        end
        else if (key_ok)
        begin
            q_cmd.op = hut_pkg::OP_PRESS_KEY;
        end
        else
        begin
            q_cmd.op = hut_pkg::OP_NONE;
        end
        // a first item after reset is classified like any other
        if (!seen_reg && !btn_ok)
        begin
            q_cmd.op = hut_pkg::OP_NONE;
        end
    end

endmodule

`default_nettype wire

### design/hut_queue.sv
// Short command queue between the classifier and the sequencer.
`default_nettype none

module hut_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  hut_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output hut_pkg::cmd_t      head
);

    hut_pkg::cmd_t            q_mem [hut_pkg::QDEPTH];
    logic [hut_pkg::Q_W-1:0]  wr_ptr_reg;
    logic [hut_pkg::Q_W-1:0]  rd_ptr_reg;
    logic [hut_pkg::Q_W:0]    cnt_reg;
    logic                     do_push;
    logic                     do_pop;

    assign full    = cnt_reg == (hut_pkg::Q_W + 1)'(hut_pkg::QDEPTH);
    assign empty   = cnt_reg == '0;
    assign head    = q_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/hut_back.sv
// Sequencer: slot store, owner counts, key count memory and result register.
`default_nettype none

module hut_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  hut_pkg::cmd_t      q_head,
    output logic               q_pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [1:0]         event_kind,
    output logic               down,
    output logic [2:0]         mouse_mask,
    output logic [1:0]         modifier_index,
    output logic [7:0]         key_usage,
    output logic [2:0]         mouse_held,
    output logic               last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_STEP  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    hut_pkg::cmd_t       cur_reg;
    hut_pkg::plan_t      plan_reg, plan_next;
    logic [7:0]          code_reg, code_next;
    logic [3:0]          mods_reg, mods_next;
    logic [2:0]          step_reg;

    logic [1:0]          slot_type_reg [hut_pkg::BUTTONS];
    logic [7:0]          slot_code_reg [hut_pkg::BUTTONS];
    logic [3:0]          slot_mods_reg [hut_pkg::BUTTONS];
    logic [1:0]          mouse_cnt_reg [hut_pkg::MOUSE_BTNS];
    logic [1:0]          mouse_cnt_next [hut_pkg::MOUSE_BTNS];
    logic [1:0]          mod_cnt_reg [hut_pkg::MODS];

    logic [1:0]                   key_mem [hut_pkg::KEY_USAGES];
    logic [hut_pkg::KEY_USAGES-1:0] key_vld_reg;
    logic [1:0]                   kdata_reg;
    logic                         kvld_rd_reg;
    logic [hut_pkg::KEY_W-1:0]    key_addr;
    logic [hut_pkg::KEY_W-1:0]    key_wr_addr;

    hut_pkg::result_t    pend_reg, pend_next;
    logic                pend_valid_reg;
    hut_pkg::result_t    out_reg;
    logic                out_valid_reg;
    logic                out_last_reg;

    logic                t_mouse, t_mod, t_key, up, active, fire, go, final_step;
    logic [1:0]          mod_b;
    logic [1:0]          midx;
    logic [1:0]          cnt, cnt_new, key_cnt;
    logic [2:0]          held;
    logic                can_push, push, push_last;
    hut_pkg::result_t    push_res;
    logic                in_step;
    logic [1:0]          cur_slot_type;

    assign q_pop         = (state_reg == S_IDLE) && !q_empty;
    assign can_push      = !out_valid_reg || !result_stall;
    assign in_step       = state_reg == S_STEP;
    assign cur_slot_type = slot_type_reg[cur_reg.slot];
    assign midx          = 2'(code_reg[1:0] - 2'd1);
    assign key_cnt       = kvld_rd_reg ? kdata_reg : 2'd0;
    assign key_addr      = code_next[hut_pkg::KEY_W-1:0];
    assign key_wr_addr   = code_reg[hut_pkg::KEY_W-1:0];

    // work out what the popped command does against its slot
    always_comb
    begin
        plan_next = hut_pkg::PL_NONE;
        code_next = cur_reg.code;
        mods_next = cur_reg.mods;
        unique case (cur_reg.op)
            hut_pkg::OP_PRESS_MOUSE:
            begin
                if (cur_slot_type == hut_pkg::TYPE_DISABLED)
                begin
                    plan_next = hut_pkg::PL_MOUSE_DN;
                end
            end
            hut_pkg::OP_PRESS_KEY:
            begin
                if (cur_slot_type == hut_pkg::TYPE_DISABLED)
                begin
                    plan_next = hut_pkg::PL_KEY_DN;
                end
            end
            hut_pkg::OP_RELEASE:
            begin
                code_next = slot_code_reg[cur_reg.slot];
                mods_next = slot_mods_reg[cur_reg.slot];
                if (cur_slot_type == hut_pkg::TYPE_MOUSE)
                begin
                    plan_next = hut_pkg::PL_MOUSE_UP;
                end
                else if (cur_slot_type == hut_pkg::TYPE_KEY)
                begin
                    plan_next = hut_pkg::PL_KEY_UP;
                end
            end
            default:
            begin
                plan_next = hut_pkg::PL_NONE;
            end
        endcase
    end

    // press order: modifiers 0..3 then key; release order: key then modifiers
    always_comb
    begin
        t_mouse    = 1'b0;
        t_mod      = 1'b0;
        t_key      = 1'b0;
        mod_b      = 2'd0;
        up         = (plan_reg == hut_pkg::PL_MOUSE_UP) || (plan_reg == hut_pkg::PL_KEY_UP);
        final_step = 1'b1;
        unique case (plan_reg)
            hut_pkg::PL_MOUSE_DN, hut_pkg::PL_MOUSE_UP:
            begin
                t_mouse = 1'b1;
            end
            hut_pkg::PL_KEY_DN:
            begin
                final_step = step_reg == hut_pkg::STEP_LAST;
                if (step_reg == hut_pkg::STEP_LAST)
                begin
                    t_key = 1'b1;
                end
                else
                begin
                    mod_b = step_reg[1:0];
                    t_mod = mods_reg[step_reg[1:0]];
                end
            end
            hut_pkg::PL_KEY_UP:
            begin
                final_step = step_reg == hut_pkg::STEP_LAST;
                if (step_reg == 3'd0)
                begin
                    t_key = 1'b1;
                end
                else
                begin
                    mod_b = 2'(step_reg - 3'd1);
                    t_mod = mods_reg[mod_b];
                end
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase

        if (t_mouse)
        begin
            cnt = mouse_cnt_reg[midx];
        end
        else if (t_mod)
        begin
            cnt = mod_cnt_reg[mod_b];
        end
        else if (t_key)
        begin
            cnt = key_cnt;
        end
        else
        begin
            cnt = 2'd0;
        end

        active = t_mouse || t_mod || t_key;
        if (up)
        begin
            cnt_new = (cnt == 2'd0) ? 2'd0 : 2'(cnt - 2'd1);
            fire    = active && (cnt == 2'd1);
        end
        else
        begin
            cnt_new = (cnt == hut_pkg::COUNT_MAX) ? cnt : 2'(cnt + 2'd1);
            fire    = active && (cnt == 2'd0);
        end
        // a new result displaces the pending one, which needs room downstream
        go = !(fire && pend_valid_reg && !can_push);
    end

    always_comb
    begin
        mouse_cnt_next = mouse_cnt_reg;
        if (in_step && go && t_mouse)
        begin
            mouse_cnt_next[midx] = cnt_new;
        end
        held = {mouse_cnt_next[2] != 2'd0, mouse_cnt_next[1] != 2'd0,
                mouse_cnt_next[0] != 2'd0};

        pend_next.kind    = t_mouse ? hut_pkg::EV_MOUSE : (t_mod ? hut_pkg::EV_MOD : hut_pkg::EV_KEY);
        pend_next.down    = !up;
        pend_next.mask    = t_mouse ? hut_pkg::host_mask(code_reg[1:0]) : 3'd0;
        pend_next.mod_idx = t_mod ? mod_b : 2'd0;
        pend_next.key     = t_key ? code_reg : 8'd0;
        pend_next.held    = held;
    end

    always_comb
    begin
        push      = 1'b0;
        push_last = 1'b0;
        push_res  = pend_reg;
        if (in_step)
        begin
            push = go && fire && pend_valid_reg;
        end
        else if (state_reg == S_FLUSH)
        begin
            push      = can_push;
            push_last = 1'b1;
            if (!pend_valid_reg)
            begin
                push_res      = '0;
                push_res.kind = hut_pkg::EV_NONE;
                push_res.held = held;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (go && final_step)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (can_push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // key counts: one read port registered, one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            kdata_reg <= key_mem[key_addr];
        end
        if (in_step && go && t_key)
        begin
            key_mem[key_wr_addr] <= cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (state_reg == S_LOAD)
        begin
            code_reg <= code_next;
            mods_reg <= mods_next;
        end
        if (in_step && go && fire)
        begin
            pend_reg <= pend_next;
        end
        if (push)
        begin
            out_reg      <= push_res;
            out_last_reg <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            plan_reg       <= hut_pkg::PL_NONE;
            step_reg       <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            kvld_rd_reg    <= 1'b0;
            key_vld_reg    <= '0;
            for (int i = 0; i < hut_pkg::BUTTONS; i++)
            begin
                slot_type_reg[i] <= hut_pkg::TYPE_DISABLED;
                slot_code_reg[i] <= 8'd0;
                slot_mods_reg[i] <= 4'd0;
            end
            for (int i = 0; i < hut_pkg::MOUSE_BTNS; i++)
            begin
                mouse_cnt_reg[i] <= 2'd0;
            end
            for (int i = 0; i < hut_pkg::MODS; i++)
            begin
                mod_cnt_reg[i] <= 2'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mouse_cnt_reg <= mouse_cnt_next;

            if (state_reg == S_LOAD)
            begin
                plan_reg       <= plan_next;
                step_reg       <= 3'd0;
                pend_valid_reg <= 1'b0;
                kvld_rd_reg    <= key_vld_reg[key_addr];
                if (plan_next == hut_pkg::PL_MOUSE_DN)
                begin
                    slot_type_reg[cur_reg.slot] <= hut_pkg::TYPE_MOUSE;
                    slot_code_reg[cur_reg.slot] <= cur_reg.code;
                    slot_mods_reg[cur_reg.slot] <= cur_reg.mods;
                end
                else if (plan_next == hut_pkg::PL_KEY_DN)
                begin
                    slot_type_reg[cur_reg.slot] <= hut_pkg::TYPE_KEY;
                    slot_code_reg[cur_reg.slot] <= cur_reg.code;
                    slot_mods_reg[cur_reg.slot] <= cur_reg.mods;
                end
                else if (cur_reg.op == hut_pkg::OP_RELEASE)
                begin
                    slot_type_reg[cur_reg.slot] <= hut_pkg::TYPE_DISABLED;
                    slot_code_reg[cur_reg.slot] <= 8'd0;
                    slot_mods_reg[cur_reg.slot] <= 4'd0;
                end
            end

            if (in_step && go)
            begin
                step_reg <= step_reg + 3'd1;
                if (fire)
                begin
                    pend_valid_reg <= 1'b1;
                end
                if (t_mod)
                begin
                    mod_cnt_reg[mod_b] <= cnt_new;
                end
                if (t_key)
                begin
                    key_vld_reg[key_wr_addr] <= 1'b1;
                end
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid   = out_valid_reg;
    assign event_kind     = out_reg.kind;
    assign down           = out_reg.down;
    assign mouse_mask     = out_reg.mask;
    assign modifier_index = out_reg.mod_idx;
    assign key_usage      = out_reg.key;
    assign mouse_held     = out_reg.held;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

### design/hid_usage_refcount_tracker_unit.sv
// Top level of the HID usage owner-count tracker.
//
// Press and release items of up to three physical buttons are classified on
// entry and queued (two commands deep); a sequencer then looks up the button
// slot, raises or lowers the owner counts of the mouse button, the four
// modifiers and the key usage, and sends one result per count that crosses
// zero, or a single no-change result, the final one flagged by last. An item
// runs through the sequencer as a pop, a load with the key-count memory read,
// one step per modifier and key (one step only for mouse, ignored or no-op
// items) and the final flush; result stalls can hold a step or the flush.
// Key counts live in a 256-entry memory whose entries are marked valid as
// they are written, so reset takes effect at once with no clearing pass.
`default_nettype none

module hid_usage_refcount_tracker_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire logic          action,
    input  wire logic [1:0]    button,
    input  wire logic [1:0]    action_type,
    input  wire logic [7:0]    target_code,
    input  wire logic [3:0]    modifier_bits,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [1:0]         event_kind,
    output logic               down,
    output logic [2:0]         mouse_mask,
    output logic [1:0]         modifier_index,
    output logic [7:0]         key_usage,
    output logic [2:0]         mouse_held,
    output logic               last
);

    hut_pkg::cmd_t  push_cmd;
    hut_pkg::cmd_t  head_cmd;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    hut_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .button        (button),
        .action_type   (action_type),
        .target_code   (target_code),
        .modifier_bits (modifier_bits),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    hut_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    hut_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (head_cmd),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .event_kind     (event_kind),
        .down           (down),
        .mouse_mask     (mouse_mask),
        .modifier_index (modifier_index),
        .key_usage      (key_usage),
        .mouse_held     (mouse_held),
        .last           (last)
    );

endmodule

`default_nettype wire
